>>> hw/rtl/prefix_expression_stack_evaluator_top_assert.svh
// Assertion macros used by the prefix expression stack evaluator RTL.
`ifndef PREFIX_EXPRESSION_STACK_EVALUATOR_TOP_ASSERT_SVH
`define PREFIX_EXPRESSION_STACK_EVALUATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PESEV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PESEV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pesev_pkg.sv
// Shared constants for the prefix expression stack evaluator.
package pesev_pkg;

    localparam int DATA_W              = 32;
    localparam int OPCODE_W            = 3;
    localparam int DEFAULT_STACK_DEPTH = 64;

    // Input request tdata width: opcode and operand, padded to whole bytes.
    localparam int IN_FIELDS_W = OPCODE_W + DATA_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // Token opcodes.
    localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_REM  = 3'd5;

endpackage

>>> hw/rtl/pesev_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pesev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/prefix_expression_stack_evaluator_top.sv
// Top level of the prefix expression stack evaluator.
//
// Tokens of a prefix expression arrive last to first on the slave stream; a request
// with tlast set ends the expression and yields one result on the master stream
// (tdata = value, tuser = illegal flag, value zero when illegal). The block takes
// one token at a time and drops tready while it works: a push or an unused opcode
// needs no further work, add and subtract do one RAM read of the second entry, then
// one pass through the shared 33-bit adder, multiply follows the read with 32
// shift-add iterations on that adder, and divide or remainder with 32 restoring
// iterations plus one sign-fix pass on the same adder. A token ignored after an
// error and an operator that finds fewer than two entries need no further work; a
// divide or remainder by zero ends after the read. A last token then passes through
// a done state that places the result in the output register once any earlier
// result there has been accepted; the placed result then waits while further tokens
// are accepted. The top of stack is held in a register and the lower entries in a
// RAM; no entry is read before it is written, so there is no clearing pass.
module prefix_expression_stack_evaluator_top #(
    parameter int STACK_DEPTH = pesev_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata fields, lowest bit up: opcode[2:0], operand_value[34:3], zero pad.
    input  logic [pesev_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata fields, lowest bit up: result_value[31:0].
    output logic [pesev_pkg::DATA_W-1:0]     m_tdata,
    // m_tuser fields, lowest bit up: illegal[0].
    output logic [0:0]                       m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    import pesev_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ITER_W = $clog2(DATA_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  error_reg, error_next;
    logic [DATA_W-1:0]     top_reg, top_next;
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic                  last_reg, last_next;
    logic [DATA_W-1:0]     acc_reg, acc_next;
    logic [DATA_W-1:0]     q_reg, q_next;
    logic [DATA_W-1:0]     m_reg, m_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic                  neg_q_reg, neg_q_next;
    logic                  neg_r_reg, neg_r_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]     out_value_reg, out_value_next;
    logic                  out_illegal_reg, out_illegal_next;

    logic [OPCODE_W-1:0]   in_opcode;
    logic [DATA_W-1:0]     in_value;
    logic                  in_accept;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic [DATA_W:0]       add_a;
    logic [DATA_W:0]       add_b;
    logic                  add_sub;
    logic [DATA_W:0]       add_sum;

    logic [DATA_W-1:0]     fix_val;
    logic                  fix_neg;
    logic [DATA_W-1:0]     left_mag;
    logic [DATA_W-1:0]     right_mag;
    logic                  iter_last;
    state_t                finish_state;
    logic                  done_wait;

    assign in_opcode = s_tdata[OPCODE_W-1:0];
    assign in_value  = s_tdata[OPCODE_W +: DATA_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_illegal_reg;

    assign iter_last    = (iter_reg == ITER_W'(DATA_W - 1));
    assign finish_state = last_reg ? S_DONE : S_IDLE;
    assign done_wait    = (state_reg == S_DONE) && out_valid_reg;

    // Operand magnitudes for the divider.
    assign left_mag  = top_reg[DATA_W-1] ? (~top_reg + DATA_W'(1)) : top_reg;
    assign right_mag = ram_rdata[DATA_W-1] ? (~ram_rdata + DATA_W'(1)) : ram_rdata;

    // Sign fix selects quotient or remainder.
    assign fix_val = (op_reg == OP_DIV) ? q_reg : acc_reg;
    assign fix_neg = (op_reg == OP_DIV) ? neg_q_reg : neg_r_reg;

    // Operand selection for the shared adder.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_READ:
            begin
                add_a   = {1'b0, top_reg};
                add_b   = {1'b0, ram_rdata};
                add_sub = (op_reg == OP_SUB);
            end
            S_MUL:
            begin
                add_a = {1'b0, acc_reg};
                add_b = q_reg[0] ? {1'b0, m_reg} : '0;
            end
            S_DIV:
            begin
                add_a   = {1'b0, acc_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                add_b   = {1'b0, m_reg};
                add_sub = 1'b1;
            end
            S_FIX:
            begin
                add_a   = fix_neg ? '0 : {1'b0, fix_val};
                add_b   = fix_neg ? {1'b0, fix_val} : '0;
                add_sub = fix_neg;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    // Shared 33-bit adder and subtractor.
    assign add_sum = add_a + (add_b ^ {(DATA_W + 1){add_sub}}) + {{DATA_W{1'b0}}, add_sub};

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        error_next       = error_reg;
        top_next         = top_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        acc_next         = acc_reg;
        q_next           = q_reg;
        m_next           = m_reg;
        iter_next        = iter_reg;
        neg_q_next       = neg_q_reg;
        neg_r_next       = neg_r_reg;
        out_valid_next   = out_valid_reg;
        out_value_next   = out_value_reg;
        out_illegal_next = out_illegal_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[ADDR_W-1:0] - ADDR_W'(1);
        ram_re           = 1'b0;
        ram_raddr        = count_reg[ADDR_W-1:0] - ADDR_W'(2);

        // The output register empties when the consumer takes the result.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = in_opcode;
                    last_next  = s_tlast;
                    state_next = s_tlast ? S_DONE : S_IDLE;
                    if (!error_reg)
                    begin
                        case (in_opcode)
                            OP_PUSH:
                            begin
                                if (count_reg == CNT_W'(STACK_DEPTH))
                                begin
                                    error_next = 1'b1;
                                end
                                else
                                begin
                                    // The old top moves down into the RAM.
                                    ram_we     = (count_reg != '0);
                                    top_next   = in_value;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM:
                            begin
                                if (count_reg < CNT_W'(2))
                                begin
                                    error_next = 1'b1;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    state_next = S_READ;
                                end
                            end
                            default:
                            begin
                                op_next = in_opcode;
                            end
                        endcase
                    end
                end
            end

            S_READ:
            begin
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        top_next   = add_sum[DATA_W-1:0];
                        count_next = count_reg - CNT_W'(1);
                        state_next = finish_state;
                    end
                    OP_MUL:
                    begin
                        acc_next   = '0;
                        q_next     = ram_rdata;
                        m_next     = top_reg;
                        iter_next  = '0;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        if (ram_rdata == '0)
                        begin
                            // Division or remainder by zero.
                            error_next = 1'b1;
                            state_next = finish_state;
                        end
                        else
                        begin
                            acc_next   = '0;
                            q_next     = left_mag;
                            m_next     = right_mag;
                            iter_next  = '0;
                            neg_q_next = top_reg[DATA_W-1] ^ ram_rdata[DATA_W-1];
                            neg_r_next = top_reg[DATA_W-1];
                            state_next = S_DIV;
                        end
                    end
                endcase
            end

            S_MUL:
            begin
                // One shift-add step of the low-half product.
                acc_next  = add_sum[DATA_W-1:0];
                m_next    = {m_reg[DATA_W-2:0], 1'b0};
                q_next    = {1'b0, q_reg[DATA_W-1:1]};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_last)
                begin
                    top_next   = add_sum[DATA_W-1:0];
                    count_next = count_reg - CNT_W'(1);
                    state_next = finish_state;
                end
            end

            S_DIV:
            begin
                // One restoring division step; a clear sign bit means it fits.
                if (!add_sum[DATA_W])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
                iter_next = iter_reg + ITER_W'(1);
                if (iter_last)
                begin
                    state_next = S_FIX;
                end
            end

            S_FIX:
            begin
                top_next   = add_sum[DATA_W-1:0];
                count_next = count_reg - CNT_W'(1);
                state_next = finish_state;
            end

            S_DONE:
            begin
                // Place the result once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (error_reg || (count_reg == '0))
                    begin
                        out_value_next   = '0;
                        out_illegal_next = 1'b1;
                    end
                    else
                    begin
                        out_value_next   = top_reg;
                        out_illegal_next = 1'b0;
                    end
                    count_next = '0;
                    error_next = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            error_reg       <= 1'b0;
            top_reg         <= '0;
            op_reg          <= OP_PUSH;
            last_reg        <= 1'b0;
            acc_reg         <= '0;
            q_reg           <= '0;
            m_reg           <= '0;
            iter_reg        <= '0;
            neg_q_reg       <= 1'b0;
            neg_r_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_value_reg   <= '0;
            out_illegal_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            error_reg       <= error_next;
            top_reg         <= top_next;
            op_reg          <= op_next;
            last_reg        <= last_next;
            acc_reg         <= acc_next;
            q_reg           <= q_next;
            m_reg           <= m_next;
            iter_reg        <= iter_next;
            neg_q_reg       <= neg_q_next;
            neg_r_reg       <= neg_r_next;
            out_valid_reg   <= out_valid_next;
            out_value_reg   <= out_value_next;
            out_illegal_reg <= out_illegal_next;
        end
    end

    // Entries below the top of stack.
    pesev_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `include "prefix_expression_stack_evaluator_top_assert.svh"

    // The stack never holds more entries than it has room for.
    `PESEV_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(STACK_DEPTH), "stack count overflow")
    // An illegal result always carries a zero value.
    `PESEV_ASSERT_SAME(a_illegal_zero, m_tvalid && m_tuser[0], m_tdata == '0, "illegal result not zero")
    // The second operand is read only when two entries are present.
    `PESEV_ASSERT_SAME(a_read_depth, ram_re, count_reg >= CNT_W'(2), "read with too few entries")
    // A pending result is not overwritten while the consumer stalls.
    `PESEV_ASSERT_NEXT(a_done_wait, done_wait && !m_tready, done_wait, "result placed over a waiting one")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the prefix expression stack evaluator top level.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pesev_pkg::*;

    localparam int STACK_DEPTH  = DEFAULT_STACK_DEPTH;
    localparam int RANDOM_ITEMS = 1000;
    localparam int NOISE_ITEMS  = 200;
    localparam int DEEP_RUNS    = 5;
    localparam int DRAIN_CYCLES = 120;

    // Opcodes the block leaves unused; they change nothing.
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              illegal;
    } eval_result_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;

    // Predicted evaluation state.
    logic [DATA_W-1:0] eval_stack [STACK_DEPTH];
    int                eval_count;
    bit                eval_error;
    eval_result_t      expected_results [$];

    int tokens_sent;
    int mismatch_count;
    int in_gap_max;
    int out_stall_max;

    prefix_expression_stack_evaluator_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Pop two entries, push the combined value; flag a short stack or a zero divisor.
    task automatic apply_operator(input logic [OPCODE_W-1:0] opcode);
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        logic [DATA_W-1:0] combined;
        longint            num;
        longint            den;
        longint            wide;
        if (eval_count < 2)
        begin
            eval_error = 1'b1;
            return;
        end
        left  = eval_stack[eval_count-1];
        right = eval_stack[eval_count-2];
        case (opcode)
            OP_ADD: combined = left + right;
            OP_SUB: combined = left - right;
            OP_MUL: combined = left * right;
            default:
            begin
                if (right == '0)
                begin
                    eval_error = 1'b1;
                    return;
                end
                // Work in 64 bits so the most negative value over minus one wraps cleanly.
                num  = $signed(left);
                den  = $signed(right);
                wide = (opcode == OP_DIV) ? num / den : num % den;
                combined = wide[DATA_W-1:0];
            end
        endcase
        eval_count--;
        eval_stack[eval_count-1] = combined;
    endtask

    // Advance the predicted state by one token; a last token yields one result.
    task automatic predict_token(input logic [OPCODE_W-1:0] opcode,
                                 input logic [DATA_W-1:0] value, input logic last);
        eval_result_t res;
        if (!eval_error)
        begin
            if (opcode == OP_PUSH)
            begin
                if (eval_count >= STACK_DEPTH)
                begin
                    eval_error = 1'b1;
                end
                else
                begin
                    eval_stack[eval_count] = value;
                    eval_count++;
                end
            end
            else if (opcode <= OP_REM)
            begin
                apply_operator(opcode);
            end
        end
        if (last)
        begin
            if (eval_error || eval_count == 0)
            begin
                res.value   = '0;
                res.illegal = 1'b1;
            end
            else
            begin
                res.value   = eval_stack[eval_count-1];
                res.illegal = 1'b0;
            end
            expected_results.insert(expected_results.size(), res);
            eval_count = 0;
            eval_error = 1'b0;
        end
    endtask

    // Send one token request after a random gap and predict its effect once accepted.
    task automatic send_token(input logic [OPCODE_W-1:0] opcode,
                              input logic [DATA_W-1:0] value, input logic last);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({value, opcode});
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tokens_sent++;
        predict_token(opcode, value, last);
    endtask

    function automatic logic [DATA_W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return OP_ADD;
            1:       return OP_SUB;
            2:       return OP_MUL;
            3:       return OP_DIV;
            default: return OP_REM;
        endcase
    endfunction

    // Pick fresh idle limits: some stretches run with no idling at all.
    task automatic shuffle_pacing();
        in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 4;
        out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
    endtask

    // Edge values, every operator, unused opcodes and malformed endings.
    task automatic test_directed_cases();
        // Sum wraps past the most positive value.
        send_token(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        send_token(OP_PUSH, 32'd1, 1'b0);
        send_token(OP_ADD, 32'h0, 1'b1);
        // Most negative over minus one: quotient wraps, remainder is zero.
        send_token(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        send_token(OP_PUSH, 32'h8000_0000, 1'b0);
        send_token(OP_DIV, 32'hFFFF_FFFF, 1'b1);
        send_token(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        send_token(OP_PUSH, 32'h8000_0000, 1'b0);
        send_token(OP_REM, 32'h0, 1'b1);
        // Division by zero is illegal.
        send_token(OP_PUSH, 32'd0, 1'b0);
        send_token(OP_PUSH, 32'd5, 1'b0);
        send_token(OP_DIV, 32'h0, 1'b1);
        // Product wraps to zero.
        send_token(OP_PUSH, 32'h0001_0000, 1'b0);
        send_token(OP_PUSH, 32'h0001_0000, 1'b0);
        send_token(OP_MUL, 32'h0, 1'b1);
        // Operator on an empty stack; the push after it is ignored.
        send_token(OP_ADD, 32'h0, 1'b0);
        send_token(OP_PUSH, 32'd5, 1'b1);
        // Unused opcode as the only token leaves the stack empty.
        send_token(OP_SPARE_7, 32'hFFFF_FFFF, 1'b1);
        // Three operands, an unused opcode in between, then subtract and remainder.
        send_token(OP_PUSH, 32'd42, 1'b0);
        send_token(OP_PUSH, 32'd9, 1'b0);
        send_token(OP_PUSH, 32'd4, 1'b0);
        send_token(OP_SPARE_6, 32'h1234_5678, 1'b0);
        send_token(OP_SUB, 32'h0, 1'b0);
        send_token(OP_REM, 32'h0, 1'b1);
        // A single operand.
        send_token(OP_PUSH, 32'd1, 1'b1);
    endtask

    // One well-formed expression with random operands and operators.
    task automatic send_expression();
        int  n_ops;
        int  ops_done;
        int  pushes_left;
        int  depth;
        int  floor_depth;
        bit  do_push;
        bit  last;
        logic [OPCODE_W-1:0] opcode;
        n_ops       = $urandom_range(0, 8);
        pushes_left = n_ops + 1;
        ops_done    = 0;
        depth       = 0;
        floor_depth = 0;
        // Now and then an extra operand sits under the expression and is ignored.
        if ($urandom_range(0, 9) == 0)
        begin
            send_token(OP_PUSH, random_operand(), 1'b0);
            depth       = 1;
            floor_depth = 1;
        end
        while (pushes_left > 0 || ops_done < n_ops)
        begin
            if ($urandom_range(0, 19) == 0)
                send_token($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7,
                           $urandom(), 1'b0);
            if (pushes_left == 0)
                do_push = 1'b0;
            else if (depth - floor_depth < 2 || ops_done == n_ops)
                do_push = 1'b1;
            else
                do_push = 1'($urandom_range(0, 1));
            if (do_push)
            begin
                pushes_left--;
                depth++;
                opcode = OP_PUSH;
            end
            else
            begin
                ops_done++;
                depth--;
                opcode = random_operator();
            end
            last = (pushes_left == 0 && ops_done == n_ops);
            send_token(opcode, do_push ? random_operand() : $urandom(), last);
        end
    endtask

    task automatic test_random_expressions();
        int start;
        start = tokens_sent;
        while (tokens_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                shuffle_pacing();
            send_expression();
        end
    endtask

    // Fill the stack near, to and past its depth, then fold a few entries.
    task automatic test_stack_depth();
        int n_push;
        int n_ops;
        for (int run = 0; run < DEEP_RUNS; run++)
        begin
            shuffle_pacing();
            n_push = (run == 0) ? STACK_DEPTH : $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 4);
            n_ops  = $urandom_range(1, 4);
            for (int i = 0; i < n_push; i++)
                send_token(OP_PUSH, random_operand(), 1'b0);
            for (int i = 0; i < n_ops; i++)
                send_token(random_operator(), $urandom(), i == n_ops - 1);
        end
    endtask

    // Random tokens of every opcode with random last marks, closed by a last token.
    task automatic test_malformed_streams();
        for (int i = 0; i < NOISE_ITEMS; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                shuffle_pacing();
            send_token(OPCODE_W'($urandom_range(0, 7)), $urandom(),
                       (i == NOISE_ITEMS - 1) || ($urandom_range(0, 3) == 0));
        end
    endtask

    // Result receiver: draws a stall before each result.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value=%0d illegal=%0b",
                             $signed(m_tdata), m_tuser[0]);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata !== want.value || m_tuser[0] !== want.illegal)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want value=%0d illegal=%0b, got value=%0d illegal=%0b",
                                 $signed(want.value), want.illegal,
                                 $signed(m_tdata), m_tuser[0]);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        eval_count     = 0;
        eval_error     = 1'b0;
        tokens_sent    = 0;
        mismatch_count = 0;
        in_gap_max     = 4;
        out_stall_max  = 4;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_expressions();
        test_stack_depth();
        test_malformed_streams();
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
